[src/lscls_pkg.sv]
// shared constants, codes and types for the calibrated level scan
package lscls_pkg;

  // item field widths
  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 4;
  localparam int CNT_W    = 4;

  // scan configuration
  localparam int MAX_SENSORS_DEF  = 9;
  localparam int SENSOR_COUNT_RST = 8;

  // scaling constants
  localparam int FULL_SCALE = 1023;
  localparam int LEVEL_STEP = 100;
  localparam int LEVEL_MAX  = 9;

  // divider operand widths: |sample - low| * 1023 and |high - low| * 100
  localparam int NUM_W = 20;
  localparam int DEN_W = 17;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CONVERT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAL_LOW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CAL_HIGH = 2'd2;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

[src/lscls_if.sv]
// valid/ready channel interfaces for command and result items
interface lscls_in_if;
  import lscls_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CHAN_W-1:0]   channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, command, channel, sample, input ready);
  modport sink   (input valid, command, channel, sample, output ready);
endinterface

interface lscls_out_if;
  import lscls_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [CHAN_W-1:0]  sensor_index;
  logic               scan_done;
  logic               span_error;

  modport source (output valid, level, sensor_index, scan_done, span_error, input ready);
  modport sink   (input valid, level, sensor_index, scan_done, span_error, output ready);
endinterface

[src/line_sensor_calibrated_level_scan.sv]
// top level: round-robin calibrated line sensor level scan
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    command, channel, sample
//   rsp       out   valid / ready    level, sensor_index, scan_done, span_error
//   cfg       in    cfg_we           cfg_data (sensor count)
//
// a convert item passes from acceptance to a loaded result through two setup states,
// the bit-serial divider, its done strobe and the load; ready returns with the load,
// so no new item is accepted until the result of a convert is loaded
// calibration write items leave the block idle and give no result
// rst is synchronous: channel pointer back to 0, sensor count to 8, no result pending
// calibration tables are not cleared by reset; a result waiting on a stalled sink
// holds the block in its final state, while a pending result does not block the next item
module line_sensor_calibrated_level_scan #(
  parameter int MAX_SENSORS = lscls_pkg::MAX_SENSORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  lscls_in_if.sink                   req,
  lscls_out_if.source                rsp,
  input  logic                       cfg_we,
  input  logic [lscls_pkg::CNT_W-1:0] cfg_data
);
  import lscls_pkg::*;

  // table index width, at least one bit
  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SCALE,
    S_DIV,
    S_FIN
  } state_t;

  state_t state;

  // configuration and scan position
  logic [CNT_W-1:0]  sensor_count;
  logic [CHAN_W-1:0] cur_chan;

  // calibration tables, undefined until written
  logic [SAMPLE_W-1:0] low_tbl  [MAX_SENSORS];
  logic [SAMPLE_W-1:0] high_tbl [MAX_SENSORS];

  // per-item working registers
  logic [SAMPLE_W-1:0] smp;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W:0]   diff;      // sample - low, signed
  logic [SAMPLE_W:0]   den;       // high - low, signed
  logic                err;
  logic                force_zero;

  // output register
  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic [CHAN_W-1:0]  out_index;
  logic               out_done;
  logic               out_err;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                req_acc;
  logic                in_range;
  logic [SAMPLE_W-1:0] diff_mag;
  logic [SAMPLE_W-1:0] den_mag;
  logic [CHAN_W:0]     active;
  logic [CHAN_W-1:0]   chan_inc;
  logic                wrap;
  logic                out_free;
  logic [LEVEL_W-1:0]  level_next;

  assign req_acc  = req.valid & req.ready;
  assign in_range = ({1'b0, req.channel} < (CHAN_W+1)'(MAX_SENSORS));
  assign out_free = ~out_valid | rsp.ready;

  // magnitudes of the signed differences, sign handled separately
  always_comb begin
    diff_mag = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    den_mag  = den[SAMPLE_W]  ? SAMPLE_W'(-den)  : den[SAMPLE_W-1:0];
  end

  // level = floor(|num| / (|den| * 100)) folds both truncating divisions into one
  always_comb begin
    div_req.start    = (state == S_SCALE);
    div_req.dividend = NUM_W'(diff_mag) * NUM_W'(FULL_SCALE);
    div_req.divisor  = DEN_W'(den_mag) * DEN_W'(LEVEL_STEP);
  end

  lscls_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sensor count clamped to 1..MAX_SENSORS
  always_comb begin
    priority if (sensor_count == '0) begin
      active = (CHAN_W+1)'(1);
    end else if ({1'b0, sensor_count} > (CHAN_W+1)'(MAX_SENSORS)) begin
      active = (CHAN_W+1)'(MAX_SENSORS);
    end else begin
      active = {1'b0, sensor_count};
    end
  end

  assign chan_inc = cur_chan + CHAN_W'(1);
  assign wrap     = ({1'b0, chan_inc} >= active);

  // clamp the quotient to the top level; sign mismatch or empty span reads as 0
  always_comb begin
    priority if (force_zero) begin
      level_next = '0;
    end else if (div_rsp.quotient > NUM_W'(LEVEL_MAX)) begin
      level_next = LEVEL_W'(LEVEL_MAX);
    end else begin
      level_next = div_rsp.quotient[LEVEL_W-1:0];
    end
  end

  // calibration tables: written by command items, read when a convert is taken
  always_ff @(posedge clk) begin
    if (req_acc && in_range && (req.command == CMD_CAL_LOW)) begin
      low_tbl[req.channel[IDX_W-1:0]] <= req.sample;
    end
    if (req_acc && in_range && (req.command == CMD_CAL_HIGH)) begin
      high_tbl[req.channel[IDX_W-1:0]] <= req.sample;
    end
    if (req_acc && (req.command == CMD_CONVERT)) begin
      lo <= low_tbl[cur_chan[IDX_W-1:0]];
      hi <= high_tbl[cur_chan[IDX_W-1:0]];
    end
  end

  // sequencer, scan position and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sensor_count <= CNT_W'(SENSOR_COUNT_RST);
      cur_chan     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        sensor_count <= cfg_data;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          // unknown command codes are taken and dropped
          if (req_acc && (req.command == CMD_CONVERT)) begin
            smp   <= req.sample;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          diff  <= {1'b0, smp} - {1'b0, lo};
          den   <= {1'b0, hi} - {1'b0, lo};
          err   <= (lo == hi);
          state <= S_SCALE;
        end
        S_SCALE: begin
          // opposite signs give a non-positive scaled value, hence level 0
          force_zero <= (den == '0) | (diff[SAMPLE_W] ^ den[SAMPLE_W]);
          state      <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_level <= level_next;
            out_index <= cur_chan;
            out_done  <= wrap;
            out_err   <= err;
            cur_chan  <= wrap ? '0 : chan_inc;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.level        = out_level;
  assign rsp.sensor_index = out_index;
  assign rsp.scan_done    = out_done;
  assign rsp.span_error   = out_err;

endmodule

[src/lscls_div.sv]
// iterative restoring divider, one quotient bit per cycle
module lscls_div (
  input  logic               clk,
  input  logic               rst,
  input  lscls_pkg::div_req_t req,
  output lscls_pkg::div_rsp_t rsp
);
  import lscls_pkg::*;

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  rem;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic              done;

  logic [DEN_W:0]    shifted;
  logic [DEN_W+1:0]  trial;
  logic              fits;
  logic [DEN_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[NUM_W-1]};
    trial    = {1'b0, shifted} - {2'b00, dvs};
    fits     = ~trial[DEN_W+1];
    rem_next = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
        cnt <= STEP_W'(NUM_W);
      end else if (cnt != '0) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], fits};
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

[dv/tb_line_sensor_calibrated_level_scan.sv]
// testbench for the calibrated line sensor level scan: directed rows, random items, level checks
module tb_line_sensor_calibrated_level_scan;
  timeunit 1ns;
  timeprecision 1ps;

  import lscls_pkg::*;

  // command 3 has no meaning in the block, it must be dropped without a result
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int IDLE_PCT    = 22;         // chance per cycle that a side holds off
  localparam int SETTLE      = 32;         // convert latency plus margin
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 135;        // useful items per random phase
  localparam int CALM_PHASE  = 4;          // phase with no idling on either side
  localparam int N_DIRECTED  = 21;
  localparam int MAX_PRINT   = 40;

  // sensor counts for the phases after the first (the first keeps the reset value)
  localparam int COUNT_PLAN [PHASES-1] = '{9, 1, 0, 15, 5, 8, 3, 9};

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [CHAN_W-1:0]  sensor_index;
    logic               scan_done;
    logic               span_error;
  } scan_result_t;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] smp;
    bit                  typed;   // want holds a hand-written result
    scan_result_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_data;

  lscls_in_if  req_if ();
  lscls_out_if rsp_if ();

  line_sensor_calibrated_level_scan dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // scan state as the block should hold it
  int              cal_low  [MAX_SENSORS_DEF];
  int              cal_high [MAX_SENSORS_DEF];
  int              cur_channel = 0;
  logic [CNT_W-1:0] sensor_count = CNT_W'(SENSOR_COUNT_RST);

  // levels still owed by the block, oldest first
  scan_result_t level_queue [$];
  scan_result_t oldest;

  stim_row_t directed_rows [N_DIRECTED];

  bit calm = 1'b0;
  int mismatches   = 0;
  int useful_items = 0;
  int n_convert    = 0;
  int n_cal        = 0;
  int n_ignored    = 0;
  int n_span_err   = 0;
  int n_rounds     = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MAX_PRINT) begin
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  // table writes, round-robin pointer and the scaled, truncated, clamped level
  task automatic predict_item(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] chan,
                              input logic [SAMPLE_W-1:0] smp,
                              output bit has_result, output scan_result_t res);
    int lo, hi, den, scaled, lvl, active, nxt;
    has_result = 1'b0;
    res = '0;
    case (cmd)
      CMD_CAL_LOW: begin
        if (chan < MAX_SENSORS_DEF) cal_low[chan] = int'(smp);
      end
      CMD_CAL_HIGH: begin
        if (chan < MAX_SENSORS_DEF) cal_high[chan] = int'(smp);
      end
      CMD_CONVERT: begin
        lo  = cal_low[cur_channel];
        hi  = cal_high[cur_channel];
        den = hi - lo;
        lvl = 0;
        if (den != 0) begin
          // int division truncates toward zero, also for inverted spans
          scaled = ((int'(smp) - lo) * FULL_SCALE) / den;
          lvl    = scaled / LEVEL_STEP;
          if (lvl < 0) lvl = 0;
          if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
        end
        // count 0 acts as one sensor, anything above the table size saturates
        active = (sensor_count == 0) ? 1 : int'(sensor_count);
        if (active > MAX_SENSORS_DEF) active = MAX_SENSORS_DEF;
        nxt = cur_channel + 1;
        res.level        = LEVEL_W'(lvl);
        res.sensor_index = CHAN_W'(cur_channel);
        res.span_error   = (den == 0);
        // a count lowered mid-round still converts the current channel, then wraps
        res.scan_done    = (nxt >= active);
        cur_channel      = res.scan_done ? 0 : nxt;
        has_result       = 1'b1;
      end
      default: ;
    endcase
  endtask

  // one item through the request channel, with random hold-off ahead of it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] chan,
                           input logic [SAMPLE_W-1:0] smp, input bit typed,
                           input scan_result_t want);
    bit has_result;
    scan_result_t pred;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.channel <= chan;
    req_if.sample  <= smp;
    do @(posedge clk); while (!req_if.ready);
    predict_item(cmd, chan, smp, has_result, pred);
    if (has_result) begin
      level_queue.push_back(typed ? want : pred);
    end
    // only items that touch state count toward the stimulus length
    if (cmd == CMD_CONVERT) begin
      n_convert++;
      useful_items++;
    end else if (cmd != CMD_UNUSED && chan < MAX_SENSORS_DEF) begin
      n_cal++;
      useful_items++;
    end else begin
      n_ignored++;
    end
  endtask

  // sender stops and waits for every owed level, then lets trailing writes finish
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (level_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_sensor_count(input logic [CNT_W-1:0] value);
    wait_for_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sensor_count = value;
  endtask

  // mostly conversions, samples often inside the current channel's window
  task automatic random_item();
    int pick, lo, hi;
    logic [CMD_W-1:0]    cmd;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] smp;
    pick = $urandom_range(0, 99);
    chan = CHAN_W'($urandom_range(0, 15));
    smp  = SAMPLE_W'($urandom_range(0, 1023));
    if (pick < 68) begin
      cmd = CMD_CONVERT;
      lo  = cal_low[cur_channel];
      hi  = cal_high[cur_channel];
      if (pick < 8) begin
        smp = (pick < 4) ? '0 : '1;
      end else if (pick < 30) begin
        smp = SAMPLE_W'($urandom_range(lo < hi ? lo : hi, lo < hi ? hi : lo));
      end
    end else if (pick < 94) begin
      cmd = pick[0] ? CMD_CAL_LOW : CMD_CAL_HIGH;
      if ($urandom_range(0, 9) != 0) chan = CHAN_W'($urandom_range(0, MAX_SENSORS_DEF - 1));
      // equal points now and then, for the span error
      if (chan < MAX_SENSORS_DEF && $urandom_range(0, 6) == 0) begin
        smp = SAMPLE_W'((cmd == CMD_CAL_LOW) ? cal_high[chan] : cal_low[chan]);
      end else if ($urandom_range(0, 9) == 0) begin
        smp = $urandom_range(0, 1) ? '1 : '0;
      end
    end else begin
      cmd = CMD_UNUSED;
    end
    send_item(cmd, chan, smp, 1'b0, '0);
  endtask

  // result side: random back-pressure, none during the calm phase
  always @(posedge clk) begin
    rsp_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (level_queue.size() == 0) begin
        report_mismatch("level item with nothing outstanding", int'(rsp_if.level), -1);
      end else begin
        oldest = level_queue.pop_front();
        if (rsp_if.level !== oldest.level)
          report_mismatch("level", int'(rsp_if.level), int'(oldest.level));
        if (rsp_if.sensor_index !== oldest.sensor_index)
          report_mismatch("sensor_index", int'(rsp_if.sensor_index),
                          int'(oldest.sensor_index));
        if (rsp_if.scan_done !== oldest.scan_done)
          report_mismatch("scan_done", int'(rsp_if.scan_done), int'(oldest.scan_done));
        if (rsp_if.span_error !== oldest.span_error)
          report_mismatch("span_error", int'(rsp_if.span_error), int'(oldest.span_error));
        if (oldest.span_error) n_span_err++;
        if (oldest.scan_done) n_rounds++;
      end
    end
  end

  initial begin
    req_if.valid   <= 1'b0;
    req_if.command <= CMD_CONVERT;
    req_if.channel <= '0;
    req_if.sample  <= '0;
    cfg_we         <= 1'b0;
    cfg_data       <= '0;

    // directed rows run at the reset sensor count of 8, starting at channel 0
    directed_rows = '{
      '{CMD_CAL_LOW,  4'd0,  10'd0,    1'b0, '0},
      '{CMD_CAL_HIGH, 4'd0,  10'd1023, 1'b0, '0},
      '{CMD_CAL_LOW,  4'd1,  10'd100,  1'b0, '0},
      '{CMD_CAL_HIGH, 4'd1,  10'd100,  1'b0, '0},   // equal points on channel 1
      '{CMD_CAL_LOW,  4'd2,  10'd1023, 1'b0, '0},
      '{CMD_CAL_HIGH, 4'd2,  10'd0,    1'b0, '0},   // inverted span on channel 2
      '{CMD_CAL_LOW,  4'd3,  10'd200,  1'b0, '0},
      '{CMD_CAL_HIGH, 4'd3,  10'd400,  1'b0, '0},
      '{CMD_CAL_LOW,  4'd4,  10'd0,    1'b0, '0},
      '{CMD_CAL_HIGH, 4'd4,  10'd1,    1'b0, '0},   // one-count span, huge gain
      '{CMD_CAL_LOW,  4'd9,  10'd5,    1'b0, '0},   // past the table, dropped
      '{CMD_CAL_HIGH, 4'd15, 10'd1023, 1'b0, '0},   // past the table, dropped
      '{CMD_UNUSED,   4'd0,  10'd512,  1'b0, '0},   // unused command, no table change
      '{CMD_CONVERT,  4'd0,  10'd1023, 1'b1, '{4'd9, 4'd0, 1'b0, 1'b0}},  // full scale clamps
      '{CMD_CONVERT,  4'd0,  10'd0,    1'b1, '{4'd0, 4'd1, 1'b0, 1'b1}},  // span error
      '{CMD_CONVERT,  4'd0,  10'd500,  1'b0, '0},
      '{CMD_CONVERT,  4'd0,  10'd100,  1'b1, '{4'd0, 4'd3, 1'b0, 1'b0}},  // below low point
      '{CMD_CONVERT,  4'd15, 10'd1023, 1'b1, '{4'd9, 4'd4, 1'b0, 1'b0}},  // channel ignored
      '{CMD_CAL_LOW,  4'd5,  10'd300,  1'b0, '0},
      '{CMD_CAL_HIGH, 4'd5,  10'd700,  1'b0, '0},
      '{CMD_CONVERT,  4'd8,  10'd500,  1'b0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].chan, directed_rows[i].smp,
                directed_rows[i].typed, directed_rows[i].want);
    end

    useful_items = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      // each switch drains the block first, so the new count lands mid-round
      if (ph > 0) set_sensor_count(CNT_W'(COUNT_PLAN[ph-1]));
      calm = (ph == CALM_PHASE);
      if (ph == 0) begin
        // every table entry gets written before any random conversion reads it
        for (int ch = 0; ch < MAX_SENSORS_DEF; ch++) begin
          send_item(CMD_CAL_LOW, CHAN_W'(ch), SAMPLE_W'($urandom_range(0, 1023)), 1'b0, '0);
          send_item(CMD_CAL_HIGH, CHAN_W'(ch), SAMPLE_W'($urandom_range(0, 1023)), 1'b0, '0);
        end
      end
      while (useful_items < (ph + 1) * PHASE_ITEMS) random_item();
    end
    calm = 1'b0;

    wait_for_results();

    $display("run covered %0d conversions, %0d table writes and %0d dropped items",
             n_convert, n_cal, n_ignored);
    $display("%0d span errors and %0d finished rounds over sensor counts 8,9,1,0,15,5,3",
             n_span_err, n_rounds);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
